/* rtl/core/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg - shared types and helpers for the JSON string unescaper
// Scan modes, result kinds, the command passed from front to back end,
// and small decode functions.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// Scan state of the front end
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_STR  = 2'd1,
		MODE_ESC  = 2'd2,
		MODE_HEX  = 2'd3
	} jsu_mode_t;

	// Result kind codes on the output channel
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// Command kinds queued between front and back end
	typedef enum logic [1:0] {
		CMD_DATA = 2'd0,  // one data byte in value[7:0]
		CMD_END  = 2'd1,  // end of string
		CMD_ERR  = 2'd2,  // parse error
		CMD_CP   = 2'd3   // code point in value, emitted as UTF-8
	} jsu_op_t;

	typedef struct packed {
		jsu_op_t     op;
		logic [15:0] value;
	} jsu_cmd_t;

	localparam int CMD_W         = $bits(jsu_cmd_t);
	localparam int QUEUE_DEPTH_D = 4;

	// UTF-8 limits and marks
	localparam logic [15:0] CP_1B_LIMIT = 16'h0080;
	localparam logic [15:0] CP_2B_LIMIT = 16'h0800;
	localparam logic [7:0]  LEAD_2B     = 8'hC0;
	localparam logic [7:0]  LEAD_3B     = 8'hE0;
	localparam logic [7:0]  CONT_MARK   = 8'h80;
	localparam logic [5:0]  CONT_MASK   = 6'h3F;

	// ASCII codes used by the scanner
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Escape letters after a backslash
	localparam logic [7:0] CH_ESC_B = 8'h62;
	localparam logic [7:0] CH_ESC_F = 8'h66;
	localparam logic [7:0] CH_ESC_N = 8'h6E;
	localparam logic [7:0] CH_ESC_R = 8'h72;
	localparam logic [7:0] CH_ESC_T = 8'h74;
	localparam logic [7:0] CH_ESC_U = 8'h75;

	// Hex digit value; valid flag in bit 4
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// Number of results a command produces, minus one
	function automatic logic [1:0] cmd_last_idx(input jsu_cmd_t cmd);
		logic [1:0] r;
		r = 2'd0;
		if (cmd.op == CMD_CP) begin
			if (cmd.value < CP_1B_LIMIT) begin
				r = 2'd0;
			end else if (cmd.value < CP_2B_LIMIT) begin
				r = 2'd1;
			end else begin
				r = 2'd2;
			end
		end
		return r;
	endfunction

endpackage

/* rtl/core/jsu_front.sv */
// ----------------------------------------------------------------------------
// jsu_front - byte classifier and escape scanner
// Tracks the string scan state and turns each accepted byte into at most
// one command for the back end.
// ----------------------------------------------------------------------------
module jsu_front
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	output logic       push,
	output jsu_cmd_t   cmd
);

	jsu_mode_t   mode_q, mode_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [15:0] acc_q, acc_d;
	logic [4:0]  hex;

	assign hex = hex_decode(in_byte);

	// Classify the byte and pick next scan state
	always_comb begin
		mode_d    = mode_q;
		hex_cnt_d = hex_cnt_q;
		acc_d     = acc_q;
		push      = 1'b0;
		cmd.op    = CMD_DATA;
		cmd.value = {8'd0, in_byte};
		unique case (mode_q)
			MODE_IDLE: begin
				if (in_byte == CH_QUOTE) begin
					mode_d    = MODE_STR;
					hex_cnt_d = 2'd0;
					acc_d     = 16'd0;
				end
			end
			MODE_STR: begin
				if (in_byte == CH_QUOTE) begin
					mode_d = MODE_IDLE;
					push   = 1'b1;
					cmd.op = CMD_END;
				end else if (in_byte < CH_SPACE) begin
					mode_d = MODE_IDLE;
					push   = 1'b1;
					cmd.op = CMD_ERR;
				end else if (in_byte == CH_BSL) begin
					mode_d = MODE_ESC;
				end else begin
					push = 1'b1;
				end
			end
			MODE_ESC: begin
				mode_d = MODE_STR;
				push   = 1'b1;
				case (in_byte) inside
					CH_QUOTE, CH_BSL, CH_SLASH: cmd.value = {8'd0, in_byte};
					CH_ESC_B: cmd.value = 16'h0008;
					CH_ESC_F: cmd.value = 16'h000C;
					CH_ESC_N: cmd.value = 16'h000A;
					CH_ESC_R: cmd.value = 16'h000D;
					CH_ESC_T: cmd.value = 16'h0009;
					CH_ESC_U: begin
						mode_d    = MODE_HEX;
						push      = 1'b0;
						hex_cnt_d = 2'd0;
						acc_d     = 16'd0;
					end
					default: begin
						mode_d = MODE_IDLE;
						cmd.op = CMD_ERR;
					end
				endcase
			end
			MODE_HEX: begin
				if (!hex[4]) begin
					mode_d = MODE_IDLE;
					push   = 1'b1;
					cmd.op = CMD_ERR;
				end else if (hex_cnt_q == 2'd3) begin
					mode_d    = MODE_STR;
					push      = 1'b1;
					cmd.op    = CMD_CP;
					cmd.value = {acc_q[11:0], hex[3:0]};
					hex_cnt_d = 2'd0;
					acc_d     = 16'd0;
				end else begin
					acc_d     = {acc_q[11:0], hex[3:0]};
					hex_cnt_d = hex_cnt_q + 2'd1;
				end
			end
			default: mode_d = MODE_IDLE;
		endcase
		// Leaving a string clears the escape context
		if (mode_d == MODE_IDLE) begin
			hex_cnt_d = 2'd0;
			acc_d     = 16'd0;
		end
		if (!accept) begin
			push = 1'b0;
		end
	end

	// Advance scan state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			hex_cnt_q <= 2'd0;
			acc_q     <= 16'd0;
		end else if (accept) begin
			mode_q    <= mode_d;
			hex_cnt_q <= hex_cnt_d;
			acc_q     <= acc_d;
		end
	end

	// Hex counter only runs while reading a unicode escape
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_HEX) |-> (hex_cnt_q == 2'd0))
		else $error("hex counter nonzero outside unicode escape");

	// Accumulator is cleared whenever the scanner is idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (acc_q == 16'd0))
		else $error("accumulator not cleared while idle");

	// A command is only queued for an accepted byte
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> accept)
		else $error("command queued without accepted byte");

endmodule

/* rtl/core/jsu_fifo.sv */
// ----------------------------------------------------------------------------
// jsu_fifo - short command queue between front and back end
// Flip-flop queue with a fill count; full and empty come from registers.
// ----------------------------------------------------------------------------
module jsu_fifo
	import jsu_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_D
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  jsu_cmd_t wdata,
	input  logic     pop,
	output jsu_cmd_t rdata,
	output logic     full,
	output logic     empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	jsu_cmd_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Store pushed command
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count out of range");

endmodule

/* rtl/core/jsu_back.sv */
// ----------------------------------------------------------------------------
// jsu_back - result emitter
// Walks each queued command through its one to three result bytes and
// holds them in the output register.
// ----------------------------------------------------------------------------
module jsu_back
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  jsu_cmd_t   head,
	input  logic       head_valid,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic       last
);

	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic [1:0] idx_q;
	logic [1:0] last_idx;
	logic       load;
	logic [1:0] kind_d;
	logic [7:0] byte_d;
	logic       last_d;

	assign last_idx = cmd_last_idx(head);
	assign load     = head_valid && (!valid_q || out_ready);
	assign last_d   = (idx_q == last_idx);
	assign pop      = load && last_d;

	// Select the result byte for the current position
	always_comb begin
		kind_d = KIND_DATA;
		byte_d = 8'd0;
		unique case (head.op)
			CMD_DATA: byte_d = head.value[7:0];
			CMD_END:  kind_d = KIND_END;
			CMD_ERR:  kind_d = KIND_ERR;
			CMD_CP: begin
				case (idx_q)
					2'd0: begin
						if (last_idx == 2'd0) begin
							byte_d = head.value[7:0];
						end else if (last_idx == 2'd1) begin
							byte_d = LEAD_2B | {3'd0, head.value[10:6]};
						end else begin
							byte_d = LEAD_3B | {4'd0, head.value[15:12]};
						end
					end
					2'd1: begin
						if (last_idx == 2'd1) begin
							byte_d = CONT_MARK | {2'd0, head.value[5:0] & CONT_MASK};
						end else begin
							byte_d = CONT_MARK | {2'd0, head.value[11:6] & CONT_MASK};
						end
					end
					default: byte_d = CONT_MARK | {2'd0, head.value[5:0] & CONT_MASK};
				endcase
			end
			default: kind_d = KIND_ERR;
		endcase
	end

	// Hold the result until taken; step through the command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last_d ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_d;
			byte_q <= byte_d;
			last_q <= last_d;
		end
	end

	assign out_valid = valid_q;
	assign kind      = kind_q;
	assign out_byte  = byte_q;
	assign last      = last_q;

	// End and error results are single, so they always carry last
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q != KIND_DATA) |-> (last_q && byte_q == 8'd0))
		else $error("end or error result malformed");

	// Position within a command never passes the third byte
	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd3)
		else $error("result position out of range");

	// A partly emitted command stays at the queue head
	assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> head_valid)
		else $error("command lost mid emission");

endmodule

/* rtl/core/json_string_unescape_utf8.sv */
// A result passes through the command queue and the output register after the input byte is accepted.
// Throughput: one input byte per cycle; one result per cycle on the output while out_ready,
// so a unicode escape yields up to three results from six input bytes.
// Input stalls only when the command queue (QUEUE_DEPTH entries) is full.
// Reset (arst_n low) returns the scanner to idle and empties queue and output.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8 - JSON string unescaper with UTF-8 output
// Front end scans bytes and escapes, queue decouples, back end emits bytes.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8
	import jsu_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic       last
);

	logic     accept;
	logic     push;
	logic     pop;
	logic     full;
	logic     empty;
	jsu_cmd_t cmd;
	jsu_cmd_t head;

	// Accept a transaction whenever the queue has room
	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	jsu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.push    (push),
		.cmd     (cmd)
	);

	jsu_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd),
		.pop    (pop),
		.rdata  (head),
		.full   (full),
		.empty  (empty)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.out_byte   (out_byte),
		.last       (last)
	);

endmodule

/* tb/sv/tb_json_string_unescape_utf8.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8 - regression for the JSON string unescaper
// Drives raw JSON text one byte per transaction and predicts the decoded
// byte stream (data, end of string, parse error) in the testbench. Random
// stalls on both channels are used. Directed strings hit plain bytes, escapes,
// unicode escapes of every UTF-8 length and each error path. Random strings,
// mostly well formed, fill the rest of the run.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8;
	import jsu_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 11;
	localparam int RANDOM_ITEMS  = 200;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;

	// Escape letters and other characters used to build JSON text
	localparam logic [7:0] ESC_B    = "b";
	localparam logic [7:0] ESC_F    = "f";
	localparam logic [7:0] ESC_N    = "n";
	localparam logic [7:0] ESC_R    = "r";
	localparam logic [7:0] ESC_T    = "t";
	localparam logic [7:0] ESC_U    = "u";
	localparam logic [7:0] ESC_BAD  = "q";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_LA    = "a";
	localparam logic [7:0] CH_LF    = "f";
	localparam logic [7:0] CH_UA    = "A";
	localparam logic [7:0] CH_UF    = "F";
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_LX    = "x";
	localparam logic [7:0] CTL_BS   = 8'h08;
	localparam logic [7:0] CTL_TAB  = 8'h09;
	localparam logic [7:0] CTL_LF   = 8'h0A;
	localparam logic [7:0] CTL_FF   = 8'h0C;
	localparam logic [7:0] CTL_CR   = 8'h0D;
	localparam logic [7:0] CTL_MAX  = 8'h1F;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       last;

	// Decoder state mirrored by the testbench
	jsu_mode_t   scan_st;
	logic [1:0]  hex_cnt;
	logic [15:0] cp_acc;

	result_t pending_results[$];
	result_t head;

	bit tx_idling;
	bit rx_idling;
	int cycle_count;
	int fail_count;
	int live_items;
	int ignored_items;
	int kind_count[3];
	int utf8_len_count[4];

	json_string_unescape_utf8 uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.out_byte  (out_byte),
		.last      (last)
	);

	// Generate the clock
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Count cycles for the run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Abort a hung run
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Value of a hex digit, or -1 when the byte is not one
	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10) return CH_ZERO + n;
		return (upper ? CH_UA : CH_LA) + (n - 4'd10);
	endfunction

	function automatic void go_idle();
		scan_st = MODE_IDLE;
		hex_cnt = 2'd0;
		cp_acc  = 16'd0;
	endfunction

	// Advance the mirrored decoder by one accepted byte and queue its results
	task automatic predict_byte(input logic [7:0] c);
		result_t     burst[$];
		result_t     r;
		int          d;
		logic [15:0] cp;
		case (scan_st)
			MODE_IDLE: begin
				if (c == CH_QUOTE) begin
					scan_st = MODE_STR;
					hex_cnt = 2'd0;
					cp_acc  = 16'd0;
				end
			end
			MODE_STR: begin
				if (c == CH_QUOTE) begin
					go_idle();
					burst.push_back('{KIND_END, 8'h00, 1'b0});
				end else if (c < CH_SPACE) begin
					go_idle();
					burst.push_back('{KIND_ERR, 8'h00, 1'b0});
				end else if (c == CH_BSL) begin
					scan_st = MODE_ESC;
				end else begin
					burst.push_back('{KIND_DATA, c, 1'b0});
				end
			end
			MODE_ESC: begin
				scan_st = MODE_STR;
				case (c) inside
					CH_QUOTE, CH_BSL, CH_SLASH: burst.push_back('{KIND_DATA, c, 1'b0});
					ESC_B: burst.push_back('{KIND_DATA, CTL_BS, 1'b0});
					ESC_F: burst.push_back('{KIND_DATA, CTL_FF, 1'b0});
					ESC_N: burst.push_back('{KIND_DATA, CTL_LF, 1'b0});
					ESC_R: burst.push_back('{KIND_DATA, CTL_CR, 1'b0});
					ESC_T: burst.push_back('{KIND_DATA, CTL_TAB, 1'b0});
					ESC_U: begin
						scan_st = MODE_HEX;
						hex_cnt = 2'd0;
						cp_acc  = 16'd0;
					end
					default: begin
						go_idle();
						burst.push_back('{KIND_ERR, 8'h00, 1'b0});
					end
				endcase
			end
			MODE_HEX: begin
				d = hex_nibble(c);
				if (d < 0) begin
					go_idle();
					burst.push_back('{KIND_ERR, 8'h00, 1'b0});
				end else begin
					cp_acc = {cp_acc[11:0], d[3:0]};
					if (hex_cnt == 2'd3) begin
						cp      = cp_acc;
						scan_st = MODE_STR;
						hex_cnt = 2'd0;
						cp_acc  = 16'd0;
						// encode as one, two or three UTF-8 bytes
						if (cp < CP_1B_LIMIT) begin
							burst.push_back('{KIND_DATA, cp[7:0], 1'b0});
						end else if (cp < CP_2B_LIMIT) begin
							burst.push_back('{KIND_DATA, LEAD_2B | {3'b000, cp[10:6]}, 1'b0});
							burst.push_back('{KIND_DATA, CONT_MARK | {2'b00, cp[5:0]}, 1'b0});
						end else begin
							burst.push_back('{KIND_DATA, LEAD_3B | {4'b0000, cp[15:12]}, 1'b0});
							burst.push_back('{KIND_DATA, CONT_MARK | {2'b00, cp[11:6]}, 1'b0});
							burst.push_back('{KIND_DATA, CONT_MARK | {2'b00, cp[5:0]}, 1'b0});
						end
						utf8_len_count[burst.size()]++;
					end else begin
						hex_cnt = hex_cnt + 2'd1;
					end
				end
			end
		endcase
		for (int i = 0; i < burst.size(); i++) begin
			r = burst[i];
			r.last = (i == burst.size() - 1);
			pending_results.push_back(r);
		end
	endtask

	// Drive one byte, hold it until the transaction completes, then predict
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		if (tx_idling && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_byte  = b;
		do @(posedge clk); while (!in_ready);
		if (scan_st != MODE_IDLE || b == CH_QUOTE) live_items++;
		else ignored_items++;
		predict_byte(b);
	endtask

	// Drop valid and hold off until every queued result has come out
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_unicode(input logic [15:0] cp);
		send_byte(CH_BSL);
		send_byte(ESC_U);
		for (int i = 3; i >= 0; i--) begin
			send_byte(hex_char(cp[i*4 +: 4], 1'($urandom_range(0, 1))));
		end
	endtask

	// Receive side: accept results with random stall bursts
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_idling && $urandom_range(0, 3) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, got kind=%0d byte=%02h last=%0d",
					$time, kind, out_byte, last);
				fail_count++;
			end else begin
				head = pending_results.pop_front();
				if (kind !== head.kind || out_byte !== head.data || last !== head.last) begin
					$display({"%0t: mismatch, expected kind=%0d byte=%02h last=%0d, ",
						"got kind=%0d byte=%02h last=%0d"},
						$time, head.kind, head.data, head.last, kind, out_byte, last);
					fail_count++;
				end
				if (kind <= KIND_ERR) kind_count[kind]++;
			end
		end
	end

	// Plain bytes at the range extremes, and bytes ignored while idle
	task automatic test_plain_bytes();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_QUOTE);
		send_byte(CH_SPACE);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(CH_QUOTE);
	endtask

	// Escapes, both one-letter and every UTF-8 length of a unicode escape
	task automatic test_escapes();
		send_byte(CH_QUOTE);
		send_byte(CH_BSL);
		send_byte(ESC_T);
		send_byte(CH_BSL);
		send_byte(CH_SLASH);
		send_unicode(16'h0000);
		send_unicode(16'h07FF);
		send_unicode(16'hD83D);
		send_byte(CH_QUOTE);
		wait_drained();
	endtask

	// Control byte, unknown escape letter, sign and x inside a unicode escape
	task automatic test_errors();
		send_byte(CH_QUOTE);
		send_byte(CTL_MAX);
		send_byte(CH_QUOTE);
		send_byte(CH_BSL);
		send_byte(ESC_BAD);
		send_byte(CH_QUOTE);
		send_byte(CH_BSL);
		send_byte(ESC_U);
		send_byte(CH_PLUS);
		send_byte(CH_QUOTE);
		send_byte(CH_BSL);
		send_byte(ESC_U);
		send_byte(CH_ZERO);
		send_byte(CH_LX);
	endtask

	// One random string, well formed or cut short by an error
	task automatic send_random_string(input bit broken);
		int          ntok;
		logic [7:0]  b;
		logic [15:0] cp;
		ntok = $urandom_range(0, 8);
		send_byte(CH_QUOTE);
		repeat (ntok) begin
			case ($urandom_range(0, 5)) inside
				[0:2]: begin
					do b = 8'($urandom_range(CH_SPACE, 8'hFF));
					while (b == CH_QUOTE || b == CH_BSL);
					send_byte(b);
				end
				3: begin
					send_byte(CH_BSL);
					case ($urandom_range(0, 7))
						0: send_byte(CH_QUOTE);
						1: send_byte(CH_BSL);
						2: send_byte(CH_SLASH);
						3: send_byte(ESC_B);
						4: send_byte(ESC_F);
						5: send_byte(ESC_N);
						6: send_byte(ESC_R);
						default: send_byte(ESC_T);
					endcase
				end
				default: begin
					case ($urandom_range(0, 4))
						0: cp = 16'($urandom_range(0, 16'h007F));
						1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
						2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
						3: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
						default: begin
							case ($urandom_range(0, 4))
								0: cp = 16'h007F;
								1: cp = 16'h0080;
								2: cp = 16'h07FF;
								3: cp = 16'h0800;
								default: cp = 16'hFFFF;
							endcase
						end
					endcase
					send_unicode(cp);
				end
			endcase
		end
		if (!broken) begin
			send_byte(CH_QUOTE);
		end else begin
			case ($urandom_range(0, 2))
				0: send_byte(8'($urandom_range(0, CTL_MAX)));
				1: begin
					send_byte(CH_BSL);
					do b = 8'($urandom_range(0, 255));
					while (b == CH_QUOTE || b == CH_BSL || b == CH_SLASH || b == ESC_B ||
						b == ESC_F || b == ESC_N || b == ESC_R || b == ESC_T || b == ESC_U);
					send_byte(b);
				end
				default: begin
					send_byte(CH_BSL);
					send_byte(ESC_U);
					repeat ($urandom_range(0, 3)) begin
						send_byte(hex_char(4'($urandom_range(0, 15)),
							1'($urandom_range(0, 1))));
					end
					do b = 8'($urandom_range(0, 255));
					while (hex_nibble(b) >= 0);
					send_byte(b);
				end
			endcase
		end
	endtask

	// Random strings with idle noise between them; quiet channels at the end
	task automatic test_random_strings();
		int         start_items;
		bit         drained_once;
		logic [7:0] b;
		start_items  = live_items;
		drained_once = 1'b0;
		while (live_items < start_items + RANDOM_ITEMS) begin
			if (!drained_once && live_items >= start_items + RANDOM_ITEMS / 2) begin
				wait_drained();
				drained_once = 1'b1;
			end
			if (live_items >= start_items + RANDOM_ITEMS * 3 / 4) begin
				tx_idling = 1'b0;
				rx_idling = 1'b0;
			end
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					do b = 8'($urandom_range(0, 255));
					while (b == CH_QUOTE);
					send_byte(b);
				end
			end
			send_random_string($urandom_range(0, 4) == 0);
		end
	endtask

	// Main sequence
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_byte   = 8'h00;
		tx_idling = 1'b1;
		rx_idling = 1'b1;
		cycle_count = 0;
		fail_count  = 0;
		live_items  = 0;
		ignored_items = 0;
		go_idle();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_plain_bytes();
		test_escapes();
		test_errors();
		test_random_strings();
		wait_drained();

		$display("Sent %0d bytes in strings and %0d ignored while idle",
			live_items, ignored_items);
		$display("Checked %0d data, %0d ends, %0d errors; unicode escapes: %0d/%0d/%0d of 1/2/3 bytes",
			kind_count[KIND_DATA], kind_count[KIND_END], kind_count[KIND_ERR],
			utf8_len_count[1], utf8_len_count[2], utf8_len_count[3]);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* json_string_unescape_utf8.f */
rtl/core/jsu_pkg.sv
rtl/core/jsu_front.sv
rtl/core/jsu_fifo.sv
rtl/core/jsu_back.sv
rtl/core/json_string_unescape_utf8.sv
tb/sv/tb_json_string_unescape_utf8.sv
